>>> hw/rtl/piecewise_linear_interpolator_top_macros.svh
// Assertion macros used by the interpolator back end.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PLI_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);
// Next-cycle implication.
`define PLI_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

>>> hw/rtl/pli_pkg.sv
// Shared types and constants of the interpolator.
package pli_pkg;
    localparam int unsigned TABLE_DEPTH = 32;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 5;
    localparam int unsigned CNT_W  = 6;
    localparam int unsigned REG_W  = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        REGION_INSIDE = 2'd0,
        REGION_LOW    = 2'd1,
        REGION_HIGH   = 2'd2
    } region_t;

    typedef struct packed {
        logic              command;
        logic [IDX_W-1:0]  entry_index;
        logic [DATA_W-1:0] x_value;
        logic [DATA_W-1:0] y_value;
    } in_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0] y_result;
        logic [IDX_W-1:0]  segment_index;
        logic [REG_W-1:0]  region;
    } out_beat_t;
endpackage

>>> hw/rtl/pli_in_if.sv
// Valid/ready channel interfaces for items, results and configuration.
interface pli_in_if;
    import pli_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [IDX_W-1:0]  entry_index;
    logic [DATA_W-1:0] x_value;
    logic [DATA_W-1:0] y_value;
    modport source (output valid, command, entry_index, x_value, y_value, input ready);
    modport sink   (input valid, command, entry_index, x_value, y_value, output ready);
endinterface

interface pli_out_if;
    import pli_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] y_result;
    logic [IDX_W-1:0]  segment_index;
    logic [REG_W-1:0]  region;
    modport source (output valid, y_result, segment_index, region, input ready);
    modport sink   (input valid, y_result, segment_index, region, output ready);
endinterface

interface pli_cfg_if;
    import pli_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/pli_front.sv
// Front end: accepts beats and queues them for the back end.
module pli_front
    import pli_pkg::*;
#(
    parameter int unsigned QDEPTH = 2
) (
    input  logic     clk,
    input  logic     rst_n,
    pli_in_if.sink   in_ch,
    output in_beat_t q_data,
    output logic     q_valid,
    input  logic     q_pop
);
    localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    in_beat_t          fifo_reg [QDEPTH];
    logic [PW-1:0]     wptr_reg, rptr_reg;
    logic [PW:0]       cnt_reg;
    logic              push;

    assign in_ch.ready = (cnt_reg != (PW+1)'(QDEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != '0);
    assign q_data      = fifo_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= '{in_ch.command, in_ch.entry_index,
                                    in_ch.x_value, in_ch.y_value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PW'(QDEPTH-1)) ? '0 : wptr_reg + 1'b1;
            end
            if (q_pop && q_valid)
            begin
                rptr_reg <= (rptr_reg == PW'(QDEPTH-1)) ? '0 : rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(q_pop && q_valid);
        end
    end
endmodule

>>> hw/rtl/pli_back.sv
// Back end: table store, binary search, serial divide and result register.
module pli_back
    import pli_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_beat_t   q_data,
    input  logic       q_valid,
    output logic       q_pop,
    input  logic [CNT_W-1:0] n_cfg,
    output logic       busy,
    pli_out_if.source  out_ch
);
`include "piecewise_linear_interpolator_top_macros.svh"
    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned NW = AW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RDN, S_CLS, S_SRCH, S_SRW, S_RDP0, S_RDP1, S_MUL,
        S_DIV, S_FIN, S_OUT
    } state_t;

    logic [DATA_W-1:0] xmem [TABLE_DEPTH];
    logic [DATA_W-1:0] ymem [TABLE_DEPTH];
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] xrd_reg, yrd_reg;

    state_t            state_reg;
    logic signed [DATA_W-1:0] xq_reg, x0_reg, y0_reg;
    logic [AW-1:0]     lo_reg, hi_reg, mid_reg, last_reg;
    logic [63:0]       p_reg, rem_reg;
    logic [33:0]       quo_reg;
    logic [32:0]       den_reg;
    logic [6:0]        dcnt_reg;
    logic              neg_reg;
    logic [32:0]       adx_reg, ady_reg;
    out_beat_t         res_reg;
    out_beat_t         out_reg;
    logic              ovalid_reg;

    logic [NW-1:0]     n_eff;
    logic [AW-1:0]     last_idx;
    logic              is_wr;

    logic [64:0]  rem_sh;
    logic signed [34:0] dx_w, dy_w, den_w;
    logic signed [35:0] sum_w;
    logic [33:0]  qsat;
    logic [65:0]  prod_w;
    out_beat_t    res_fin;

    always_comb
    begin
        n_eff = (n_cfg == '0) ? NW'(1) :
                ({1'b0, n_cfg} > 7'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(n_cfg);
        last_idx = AW'(n_eff - NW'(1));
    end

    assign is_wr = q_valid && (state_reg == S_IDLE) && (q_data.command == CMD_WRITE);
    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign busy  = (state_reg != S_IDLE) || q_valid || ovalid_reg;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:       raddr = '0;
            S_RD0, S_RDN: raddr = last_reg;
            S_SRCH:       raddr = mid_reg;
            S_RDP1:       raddr = lo_reg + 1'b1;
            default:      raddr = lo_reg;
        endcase
    end

    // Table store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (is_wr && ({1'b0, q_data.entry_index} < 6'(TABLE_DEPTH)))
        begin
            xmem[AW'(q_data.entry_index)] <= q_data.x_value;
            ymem[AW'(q_data.entry_index)] <= q_data.y_value;
        end
        xrd_reg <= xmem[raddr];
        yrd_reg <= ymem[raddr];
    end

    always_comb
    begin
        rem_sh  = {rem_reg, p_reg[63]};
        dx_w    = 35'(xq_reg) - 35'(x0_reg);
        dy_w    = 35'($signed(yrd_reg)) - 35'(y0_reg);
        den_w   = 35'($signed(xrd_reg)) - 35'(x0_reg);
        prod_w  = adx_reg * ady_reg;
        qsat    = (quo_reg > 34'h200000000) ? 34'h200000000 : quo_reg;
        sum_w   = 36'(y0_reg) + (neg_reg ? -36'($signed({1'b0, qsat}))
                                          : 36'($signed({1'b0, qsat})));
        res_fin = res_reg;
        if (res_reg.region == REGION_INSIDE && den_reg != '0)
        begin
            if (sum_w > 36'sh7FFFFFFF)
                res_fin.y_result = 32'h7FFFFFFF;
            else if (sum_w < -36'sh80000000)
                res_fin.y_result = 32'h80000000;
            else
                res_fin.y_result = sum_w[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            out_reg    <= '0;
            res_reg    <= '0;
            xq_reg     <= '0;
            x0_reg     <= '0;
            y0_reg     <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            mid_reg    <= '0;
            last_reg   <= '0;
            p_reg      <= '0;
            rem_reg    <= '0;
            quo_reg    <= '0;
            den_reg    <= '0;
            dcnt_reg   <= '0;
            neg_reg    <= 1'b0;
            adx_reg    <= '0;
            ady_reg    <= '0;
        end
        else
        begin
            if (state_reg == S_OUT && (!ovalid_reg || out_ch.ready))
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && q_data.command == CMD_QUERY)
                    begin
                        xq_reg   <= q_data.x_value;
                        last_reg <= last_idx;
                        state_reg <= S_RD0;
                    end
                end
                S_RD0:
                begin
                    // first entry is on the read port now
                    x0_reg <= xrd_reg;
                    y0_reg <= yrd_reg;
                    state_reg <= S_RDN;
                end
                S_RDN: state_reg <= S_CLS;
                S_CLS:
                begin
                    if (xq_reg <= x0_reg)
                    begin
                        res_reg <= '{y0_reg, '0, REGION_LOW};
                        state_reg <= S_OUT;
                    end
                    else if (xq_reg >= $signed(xrd_reg))
                    begin
                        res_reg <= '{yrd_reg, IDX_W'(last_reg), REGION_HIGH};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        lo_reg  <= '0;
                        hi_reg  <= last_reg;
                        mid_reg <= AW'(({1'b0, last_reg} + 1'b1) >> 1);
                        state_reg <= (last_reg == '0) ? S_RDP0 : S_SRCH;
                    end
                end
                S_SRCH: state_reg <= S_SRW;
                S_SRW:
                begin
                    if ($signed(xrd_reg) <= xq_reg)
                    begin
                        lo_reg <= mid_reg;
                        mid_reg <= AW'(({1'b0, mid_reg} + {1'b0, hi_reg} + 1'b1) >> 1);
                        state_reg <= (mid_reg == hi_reg) ? S_RDP0 : S_SRCH;
                    end
                    else
                    begin
                        hi_reg <= mid_reg - 1'b1;
                        mid_reg <= AW'(({1'b0, lo_reg} + {1'b0, mid_reg}) >> 1);
                        state_reg <= (lo_reg == mid_reg - 1'b1) ? S_RDP0 : S_SRCH;
                    end
                end
                S_RDP0:
                begin
                    if (lo_reg > last_reg - 1'b1)
                        lo_reg <= last_reg - 1'b1;
                    state_reg <= S_RDP1;
                end
                S_RDP1:
                begin
                    // lower entry arrives first, upper one next cycle
                    x0_reg <= xrd_reg;
                    y0_reg <= yrd_reg;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    adx_reg <= dx_w[34] ? 33'(-dx_w) : 33'(dx_w);
                    ady_reg <= dy_w[34] ? 33'(-dy_w) : 33'(dy_w);
                    den_reg <= den_w[34] ? 33'(-den_w) : 33'(den_w);
                    neg_reg <= (dx_w[34] ^ dy_w[34] ^ den_w[34]) && dx_w != 0 && dy_w != 0;
                    res_reg <= '{y0_reg, IDX_W'(lo_reg), REGION_INSIDE};
                    dcnt_reg <= '0;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    p_reg   <= prod_w[63:0];
                    rem_reg <= '0;
                    quo_reg <= '0;
                    state_reg <= (den_reg == '0) ? S_OUT : S_DIV;
                end
                S_DIV:
                begin
                    if (rem_sh >= 65'(den_reg))
                    begin
                        rem_reg <= 64'(rem_sh - 65'(den_reg));
                        quo_reg <= {quo_reg[32:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= 64'(rem_sh);
                        quo_reg <= {quo_reg[32:0], 1'b0};
                    end
                    p_reg <= p_reg << 1;
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 7'd63)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ovalid_reg || out_ch.ready)
                    begin
                        out_reg <= res_fin;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid         = ovalid_reg;
    assign out_ch.y_result      = out_reg.y_result;
    assign out_ch.segment_index = out_reg.segment_index;
    assign out_ch.region        = out_reg.region;

    `PLI_ASSERT_NXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid,
        "result dropped while stalled")
    `PLI_ASSERT_IMP(a_no_pop_busy, clk, rst_n, q_pop, state_reg == S_IDLE,
        "queue popped while busy")
    `PLI_ASSERT_IMP(a_region_ok, clk, rst_n, out_ch.valid, out_ch.region <= REGION_HIGH,
        "bad region code")
endmodule

>>> hw/rtl/piecewise_linear_interpolator_top.sv
// Top level of the piecewise-linear interpolator.
// A query beat runs from acceptance to its result beat through the table reads that
// classify it (S_RD0, S_RDN, S_CLS), a binary search (up to five steps over 32
// entries, each a read in S_SRCH and a compare in S_SRW, as the table read port is
// registered), the segment fetch and product (S_RDP0, S_RDP1, S_MUL, S_FIN), then a
// 64-step restoring divide that produces one quotient bit per cycle; the divider sets
// the rate. A clamped query goes from S_CLS straight to its result. Table writes are
// stored from the idle state. A two-beat queue separates intake from the back end,
// and a result register lets the next query run while a result beat waits. The entry
// count register accepts a write only while the block is idle.
module piecewise_linear_interpolator_top
    import pli_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pli_in_if.sink     in_ch,
    pli_out_if.source  out_ch,
    pli_cfg_if.sink    cfg
);
    in_beat_t         q_data;
    logic             q_valid, q_pop, busy;
    logic [CNT_W-1:0] n_reg;

    // entries_in_use register, reset to two breakpoints; written only when idle
    assign cfg.ready = !busy;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_reg <= CNT_W'(2);
        else if (cfg.valid && cfg.ready)
            n_reg <= cfg.data;
    end

    pli_front u_front (
        .clk, .rst_n, .in_ch, .q_data, .q_valid, .q_pop
    );

    pli_back u_back (
        .clk, .rst_n, .q_data, .q_valid, .q_pop, .n_cfg(n_reg), .busy, .out_ch
    );
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the piecewise-linear interpolator top level.
module tb_top;
    import pli_pkg::*;

    localparam int unsigned DEPTH       = 32;
    localparam int unsigned SETTLE      = 120;   // margin for the longest query to finish
    localparam int unsigned STALL_LIMIT = 4000;  // cycles with no beat on any channel

    // One queued stimulus step: either a data beat or a register write.
    typedef struct {
        bit         is_cfg;
        bit         burst;   // no idling while this job is driven
        logic [5:0] cnt;
        in_beat_t   beat;
    } job_t;

    logic clk;
    logic rst_n;

    pli_in_if  in_ch ();
    pli_out_if out_ch ();
    pli_cfg_if cfg ();

    piecewise_linear_interpolator_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // Predictor state: breakpoint table and entry count as the block sees them.
    longint     bp_x [DEPTH];
    longint     bp_y [DEPTH];
    logic [5:0] entry_count = 6'd2;

    // Generator-side copy of the table, used only to aim queries.
    longint     gen_x [DEPTH];

    job_t       jobs [$];
    out_beat_t  expected_results [$];
    int         errors = 0;
    int         quiet_cycles = 0;
    int         stall_cycles = 0;
    bit         burst_now = 0;

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    // Expected answer for one query, given the current table and entry count.
    function automatic out_beat_t interpolate(input logic [31:0] xq);
        out_beat_t  r;
        longint     xv, x0, y0, x1, y1, dx, dy, den, res, sq;
        bit [63:0]  p, q;
        int         n, seg, lo, hi, mid;
        bit         neg;
        xv = longint'($signed(xq));
        n = (entry_count == 0) ? 1 : (entry_count > DEPTH) ? DEPTH : int'(entry_count);
        if (xv <= bp_x[0])
        begin
            res = bp_y[0];
            seg = 0;
            r.region = REGION_LOW;
        end
        else if (xv >= bp_x[n-1])
        begin
            res = bp_y[n-1];
            seg = n - 1;
            r.region = REGION_HIGH;
        end
        else
        begin
            // last breakpoint at or below the query, same halving as the hardware
            lo = 0;
            hi = n - 1;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                if (bp_x[mid] <= xv)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            seg = (hi > n - 2) ? n - 2 : hi;
            x0 = bp_x[seg];
            y0 = bp_y[seg];
            x1 = bp_x[seg+1];
            y1 = bp_y[seg+1];
            dx = xv - x0;
            dy = y1 - y0;
            den = x1 - x0;
            r.region = REGION_INSIDE;
            if (den == 0)
                res = y0;
            else
            begin
                p = 64'(dx < 0 ? -dx : dx) * 64'(dy < 0 ? -dy : dy);
                q = p / 64'(den < 0 ? -den : den);
                neg = ((dx < 0) != (dy < 0)) != (den < 0);
                if (p == 0)
                    neg = 0;
                if (q > 64'h2_0000_0000)
                    q = 64'h2_0000_0000;
                sq = neg ? -longint'(q) : longint'(q);
                res = y0 + sq;
                if (res > 64'sd2147483647)
                    res = 64'sd2147483647;
                if (res < -64'sd2147483648)
                    res = -64'sd2147483648;
            end
        end
        r.y_result = res[31:0];
        r.segment_index = seg[4:0];
        return r;
    endfunction

    // Driver: takes note of accepted beats, then presents the next job.
    always @(posedge clk or negedge rst_n)
    begin
        job_t j;
        bit   in_hold, cfg_hold, nv, ncv;
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.command     <= CMD_WRITE;
            in_ch.entry_index <= '0;
            in_ch.x_value     <= '0;
            in_ch.y_value     <= '0;
            cfg.valid         <= 1'b0;
            cfg.data          <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.command == CMD_WRITE)
                begin
                    bp_x[in_ch.entry_index] = longint'($signed(in_ch.x_value));
                    bp_y[in_ch.entry_index] = longint'($signed(in_ch.y_value));
                end
                else
                    expected_results.push_back(interpolate(in_ch.x_value));
            end
            if (cfg.valid && cfg.ready)
                entry_count = cfg.data;

            in_hold  = in_ch.valid && !in_ch.ready;
            cfg_hold = cfg.valid && !cfg.ready;
            nv  = in_hold;
            ncv = cfg_hold;
            // quiet time counts only once nothing is in flight
            if (expected_results.size() != 0 || in_ch.valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;

            if (!in_hold && !cfg_hold && jobs.size() != 0)
            begin
                burst_now = jobs[0].burst;
                if (jobs[0].is_cfg)
                begin
                    // register writes only once the block has drained
                    if (quiet_cycles >= SETTLE)
                    begin
                        j = jobs.pop_front();
                        ncv = 1'b1;
                        cfg.data <= j.cnt;
                    end
                end
                else if (jobs[0].burst || $urandom_range(99) >= 31)
                begin
                    j = jobs.pop_front();
                    nv = 1'b1;
                    in_ch.command     <= j.beat.command;
                    in_ch.entry_index <= j.beat.entry_index;
                    in_ch.x_value     <= j.beat.x_value;
                    in_ch.y_value     <= j.beat.y_value;
                end
            end
            in_ch.valid <= nv;
            cfg.valid   <= ncv;
        end
    end

    // Monitor: random back-pressure and in-order compare of result beats.
    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("MISMATCH unexpected result beat y=%h at %0t",
                             out_ch.y_result, $realtime);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_ch.y_result !== want.y_result)
                        report_mismatch("y_result", out_ch.y_result, want.y_result);
                    if (out_ch.segment_index !== want.segment_index)
                        report_mismatch("segment_index", 32'(out_ch.segment_index),
                                        32'(want.segment_index));
                    if (out_ch.region !== want.region)
                        report_mismatch("region", 32'(out_ch.region), 32'(want.region));
                end
            end
            out_ch.ready <= burst_now || ($urandom_range(99) >= 31);
        end
    end

    // Watchdog: a run with no beat on any channel for too long is hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg.valid && cfg.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---- stimulus helpers ----------------------------------------------------------

    int  item_total = 0;
    bit  burst_phase = 0;

    task automatic push_write(input int idx, input logic [31:0] xv, input logic [31:0] yv);
        job_t j;
        j.is_cfg = 0;
        j.burst = burst_phase;
        j.cnt = '0;
        j.beat.command = CMD_WRITE;
        j.beat.entry_index = idx[4:0];
        j.beat.x_value = xv;
        j.beat.y_value = yv;
        jobs.push_back(j);
        gen_x[idx] = longint'($signed(xv));
        item_total++;
    endtask

    task automatic push_query(input logic [31:0] xv);
        job_t j;
        j.is_cfg = 0;
        j.burst = burst_phase;
        j.cnt = '0;
        j.beat.command = CMD_QUERY;
        j.beat.entry_index = 5'($urandom);   // don't care on a query, toggled anyway
        j.beat.x_value = xv;
        j.beat.y_value = $urandom;
        jobs.push_back(j);
        item_total++;
    endtask

    task automatic push_count(input logic [5:0] c);
        job_t j;
        j.is_cfg = 1;
        j.burst = burst_phase;
        j.cnt = c;
        j.beat = '0;
        jobs.push_back(j);
    endtask

    // Random value, often scaled down so tables span narrow as well as wide ranges.
    function automatic logic [31:0] scaled_rand(input int shift);
        return 32'($signed($urandom) >>> shift);
    endfunction

    // Fill entries 0..n-1; sorted unless noisy, with an occasional repeated x.
    task automatic load_table(input int n, input bit noisy);
        int          shift;
        logic [31:0] xs [$];
        shift = 8 * $urandom_range(3);
        for (int i = 0; i < n; i++)
            xs.push_back(scaled_rand(shift));
        if (!noisy)
        begin
            xs.sort() with (longint'($signed(item)));
            for (int i = 1; i < n; i++)
                if ($urandom_range(7) == 0)
                    xs[i] = xs[i-1];
        end
        for (int i = 0; i < n; i++)
            push_write(i, xs[i], scaled_rand(8 * $urandom_range(3)));
    endtask

    // Query aimed at the active table: ends, breakpoints, inside segments, anywhere.
    task automatic aimed_query(input int n);
        int     k;
        longint a, b, span;
        k = $urandom_range(n - 1);
        case ($urandom_range(9))
            0: push_query(32'h8000_0000);
            1: push_query(32'h7fff_ffff);
            2: push_query($urandom);
            3: push_query(gen_x[k][31:0]);
            default:
            begin
                a = gen_x[k];
                b = (k + 1 < n) ? gen_x[k+1] : a + 1000;
                if (b < a)
                begin
                    span = a;
                    a = b;
                    b = span;
                end
                span = b - a + 1;
                push_query(32'(a + longint'({$urandom, $urandom} % 64'(span))));
            end
        endcase
    endtask

    initial
    begin
        int          n;
        logic [5:0]  c;
        int          phase;

        // Directed: full-range table whose y swings between the extremes.
        push_count(6'd32);
        for (int i = 0; i < DEPTH; i++)
            push_write(i, 32'(-64'sd2147483648 + longint'(i) * 64'd138547332),
                       (i % 2) ? 32'h7fff_ffff : 32'h8000_0000);
        push_query(32'h8000_0000);             // at first breakpoint: clamped low
        push_query(32'h7fff_ffff);             // above last: clamped high
        push_query(32'h0000_0000);
        push_query(gen_x[7][31:0]);            // exactly on a breakpoint
        push_query(32'(gen_x[20] + 12345));
        // single entry: only clamping is possible
        push_count(6'd1);
        push_query(gen_x[0][31:0]);
        push_query(32'(gen_x[0] + 1));
        // a zero count acts as one entry, an oversized count as the full table
        push_count(6'd0);
        push_query(32'h7fff_ffff);
        push_count(6'd63);
        push_query(32'h7fff_fff0);
        // non-monotonic table: both queries land on a clamped end
        push_count(6'd3);
        push_write(0, 32'd0, 32'd0);
        push_write(1, 32'd100, 32'h7fff_0000);
        push_write(2, 32'd1, 32'h8000_0000);
        push_query(32'd50);
        push_query(32'd0);

        // Random phases: new count, a fresh table, then queries aimed at it.
        phase = 0;
        while (item_total < 1500)
        begin
            burst_phase = (phase == 4 || phase == 5);
            case ($urandom_range(9))
                0: c = 6'd0;
                1: c = 6'd1;
                2: c = 6'd32;
                3: c = 6'd63;
                default: c = 6'($urandom_range(32, 2));
            endcase
            push_count(c);
            n = (c == 0) ? 1 : (c > DEPTH) ? DEPTH : int'(c);
            load_table(n, $urandom_range(4) == 0);
            repeat ($urandom_range(60, 30))
            begin
                // a stray rewrite of an entry now and then, keeping it written
                if ($urandom_range(15) == 0)
                    push_write($urandom_range(DEPTH - 1), scaled_rand(8), $urandom);
                else
                    aimed_query(n);
            end
            phase++;
        end
        burst_phase = 0;

        wait (rst_n === 1'b1);
        do
            @(posedge clk);
        while (jobs.size() != 0 || in_ch.valid || cfg.valid
               || expected_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
